/* rtl/tpqf_pkg.sv */
// Shared widths, types and constants of the three-point quadratic fit.
`default_nettype none
package tpqf_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned COEF_W     = 64;

  localparam int unsigned DIFF_W  = COORD_BITS + 1;
  localparam int unsigned PROD_W  = 2 * COORD_BITS;
  localparam int unsigned TERM_W  = COORD_BITS + DIFF_W;
  localparam int unsigned DDEN_W  = 2 * DIFF_W;
  localparam int unsigned DEN_W   = 3 * DIFF_W;
  localparam int unsigned NUMA_W  = TERM_W + 2;
  localparam int unsigned UTERM_W = TERM_W + DIFF_W;
  localparam int unsigned VTERM_W = TERM_W + PROD_W;
  localparam int unsigned NUM_W   = VTERM_W + 2;
  localparam int unsigned QUO_W   = NUM_W + FRAC_BITS;
  localparam int unsigned CNT_W   = $clog2(QUO_W + 1);
  localparam int unsigned LANES   = 3;

  localparam logic [1:0] HELD_FULL = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    logic   singular;
  } job_t;

endpackage
`default_nettype wire

/* rtl/tpqf_if.sv */
// Request channels of the fit: point input and coefficient output.
`default_nettype none
interface tpqf_in_if;
  import tpqf_pkg::*;
  logic   valid;
  logic   ready;
  logic   start_list;
  coord_t point_x;
  coord_t point_y;
  modport source (output valid, output start_list, output point_x, output point_y,
                  input ready);
  modport sink (input valid, input start_list, input point_x, input point_y,
                output ready);
endinterface

interface tpqf_out_if;
  import tpqf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coef_a;
  logic signed [COEF_W-1:0] coef_b;
  logic signed [COEF_W-1:0] coef_c;
  logic                     singular;
  logic                     saturated;
  modport source (output valid, output coef_a, output coef_b, output coef_c,
                  output singular, output saturated, input ready);
  modport sink (input valid, input coef_a, input coef_b, input coef_c,
                input singular, input saturated, output ready);
endinterface
`default_nettype wire

/* rtl/tpqf_front.sv */
// Front end: point window, classification and job issue.
`default_nettype none
module tpqf_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  tpqf_in_if.sink             in_i,
  input  wire logic           full_i,
  output tpqf_pkg::job_t      job_o,
  output logic                push_o
);
  import tpqf_pkg::*;

  coord_t     older_x_q, older_y_q, newer_x_q, newer_y_q;
  logic [1:0] held_q, held_eff, held_d;
  logic       accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign held_eff   = in_i.start_list ? 2'd0 : held_q;
  assign held_d     = (held_eff == HELD_FULL) ? HELD_FULL : held_eff + 2'd1;
  assign push_o     = accept && (held_eff == HELD_FULL);

  always_comb begin
    job_o.x0 = older_x_q;
    job_o.y0 = older_y_q;
    job_o.x1 = newer_x_q;
    job_o.y1 = newer_y_q;
    job_o.x2 = in_i.point_x;
    job_o.y2 = in_i.point_y;
    job_o.singular = (older_x_q == newer_x_q) || (older_x_q == in_i.point_x) ||
                     (newer_x_q == in_i.point_x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_x_q <= '0;
      older_y_q <= '0;
      newer_x_q <= '0;
      newer_y_q <= '0;
      held_q    <= '0;
    end else if (accept) begin
      older_x_q <= newer_x_q;
      older_y_q <= newer_y_q;
      newer_x_q <= in_i.point_x;
      newer_y_q <= in_i.point_y;
      held_q    <= held_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/tpqf_fifo.sv */
// Two-entry job queue between the front end and the solver.
`default_nettype none
module tpqf_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tpqf_pkg::job_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output tpqf_pkg::job_t      data_o
);
  import tpqf_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

/* rtl/tpqf_div.sv */
// Restoring divider lane: one quotient bit per cycle.
`default_nettype none
module tpqf_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [tpqf_pkg::QUO_W-1:0]  dividend_i,
  input  wire logic [tpqf_pkg::DEN_W-1:0]  divisor_i,
  output logic                             busy_o,
  output logic [tpqf_pkg::QUO_W-1:0]       quotient_o
);
  import tpqf_pkg::*;

  logic [QUO_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;

  assign trial      = {rem_q, quo_q[QUO_W-1]};
  assign fits       = trial >= {1'b0, den_q};
  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[QUO_W-2:0], fits};
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QUO_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* rtl/tpqf_back.sv */
// Solver back end: numerator and determinant steps, three divider lanes, result.
`default_nettype none
module tpqf_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire tpqf_pkg::job_t job_i,
  output logic                pop_o,
  tpqf_out_if.source          out_o
);
  import tpqf_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL1 = 6'b000010,
    ST_MUL2 = 6'b000100,
    ST_MUL3 = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  job_t   job_q;

  logic signed [DIFF_W-1:0]  d01, d02, d12;
  logic signed [DIFF_W-1:0]  d12_q, s12_q, s02_q, s01_q;
  logic signed [PROD_W-1:0]  p12_q, p02_q, p01_q;
  logic signed [TERM_W-1:0]  t0_q, t1_q, t2_q;
  logic signed [DDEN_W-1:0]  dd_q;
  logic signed [DEN_W-1:0]   den_q;
  logic signed [NUMA_W-1:0]  na_q;
  logic signed [UTERM_W-1:0] u0_q, u1_q, u2_q;
  logic signed [VTERM_W-1:0] v0_q, v1_q, v2_q;
  logic signed [NUM_W-1:0]   num [LANES];
  logic [NUM_W-1:0]          num_mag [LANES];
  logic [QUO_W-1:0]          dividend [LANES];
  logic [QUO_W-1:0]          quotient [LANES];
  logic [LANES-1:0]          busy, neg_q;
  logic [DEN_W-1:0]          den_mag;
  logic [COEF_W:0]           clip [LANES];
  logic                      start_div, finish;

  logic signed [COEF_W-1:0]  coef_q [LANES];
  logic                      singular_q, saturated_q, valid_q;

  function automatic logic [COEF_W:0] clip_quotient(logic [QUO_W-1:0] q, logic neg);
    localparam int unsigned SW = (QUO_W > COEF_W + 1) ? QUO_W : COEF_W + 1;
    logic [SW-1:0]     qx;
    logic [SW-1:0]     lim;
    logic [COEF_W-1:0] mag;
    logic              sat;
    qx  = SW'(q);
    lim = neg ? (SW'(1) << (COEF_W - 1)) : ((SW'(1) << (COEF_W - 1)) - SW'(1));
    sat = qx > lim;
    mag = sat ? lim[COEF_W-1:0] : qx[COEF_W-1:0];
    return {sat, neg ? (COEF_W'(0) - mag) : mag};
  endfunction

  assign d01 = DIFF_W'(job_q.x0) - DIFF_W'(job_q.x1);
  assign d02 = DIFF_W'(job_q.x0) - DIFF_W'(job_q.x2);
  assign d12 = DIFF_W'(job_q.x1) - DIFF_W'(job_q.x2);

  assign num[0] = NUM_W'(na_q);
  assign num[1] = -NUM_W'(u0_q) + NUM_W'(u1_q) - NUM_W'(u2_q);
  assign num[2] = NUM_W'(v0_q) - NUM_W'(v1_q) + NUM_W'(v2_q);
  assign den_mag = den_q[DEN_W-1] ? DEN_W'(-den_q) : DEN_W'(den_q);

  assign start_div = (state_q == ST_MUL3) && !job_q.singular;
  assign finish    = (state_q == ST_DIV) && (busy == '0);
  assign pop_o     = (state_q == ST_IDLE) && !empty_i;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign num_mag[i]  = num[i][NUM_W-1] ? NUM_W'(-num[i]) : NUM_W'(num[i]);
    assign dividend[i] = QUO_W'(num_mag[i]) << FRAC_BITS;
    assign clip[i]     = clip_quotient(quotient[i], neg_q[i]);
    tpqf_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (start_div),
      .dividend_i (dividend[i]),
      .divisor_i  (den_mag),
      .busy_o     (busy[i]),
      .quotient_o (quotient[i])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (!empty_i) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = job_q.singular ? ST_OUT : ST_DIV;
      ST_DIV:  if (finish) state_d = ST_OUT;
      ST_OUT:  if (out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    if (state_q == ST_MUL1) begin
      d12_q <= d12;
      s12_q <= DIFF_W'(job_q.x1) + DIFF_W'(job_q.x2);
      s02_q <= DIFF_W'(job_q.x0) + DIFF_W'(job_q.x2);
      s01_q <= DIFF_W'(job_q.x0) + DIFF_W'(job_q.x1);
      p12_q <= PROD_W'(job_q.x1) * PROD_W'(job_q.x2);
      p02_q <= PROD_W'(job_q.x0) * PROD_W'(job_q.x2);
      p01_q <= PROD_W'(job_q.x0) * PROD_W'(job_q.x1);
      t0_q  <= TERM_W'(job_q.y0) * TERM_W'(d12);
      t1_q  <= TERM_W'(job_q.y1) * TERM_W'(d02);
      t2_q  <= TERM_W'(job_q.y2) * TERM_W'(d01);
      dd_q  <= DDEN_W'(d01) * DDEN_W'(d02);
    end
    if (state_q == ST_MUL2) begin
      den_q <= DEN_W'(dd_q) * DEN_W'(d12_q);
      na_q  <= NUMA_W'(t0_q) - NUMA_W'(t1_q) + NUMA_W'(t2_q);
      u0_q  <= UTERM_W'(t0_q) * UTERM_W'(s12_q);
      u1_q  <= UTERM_W'(t1_q) * UTERM_W'(s02_q);
      u2_q  <= UTERM_W'(t2_q) * UTERM_W'(s01_q);
      v0_q  <= VTERM_W'(t0_q) * VTERM_W'(p12_q);
      v1_q  <= VTERM_W'(t1_q) * VTERM_W'(p02_q);
      v2_q  <= VTERM_W'(t2_q) * VTERM_W'(p01_q);
    end
    if (start_div) begin
      for (int i = 0; i < LANES; i++) begin
        neg_q[i] <= num[i][NUM_W-1] ^ den_q[DEN_W-1];
      end
    end
    if ((state_q == ST_MUL3) && job_q.singular) begin
      coef_q[0]   <= COEF_W'(job_q.y0) <<< FRAC_BITS;
      coef_q[1]   <= COEF_W'(job_q.y1) <<< FRAC_BITS;
      coef_q[2]   <= COEF_W'(job_q.y2) <<< FRAC_BITS;
      singular_q  <= 1'b1;
      saturated_q <= 1'b0;
    end else if (finish) begin
      for (int i = 0; i < LANES; i++) begin
        coef_q[i] <= clip[i][COEF_W-1:0];
      end
      singular_q  <= 1'b0;
      saturated_q <= clip[0][COEF_W] | clip[1][COEF_W] | clip[2][COEF_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_d == ST_OUT);
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.coef_a    = coef_q[0];
  assign out_o.coef_b    = coef_q[1];
  assign out_o.coef_c    = coef_q[2];
  assign out_o.singular  = singular_q;
  assign out_o.saturated = saturated_q;

  a_sing_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.singular |-> !out_o.saturated)
    else $error("singular result flagged as saturated");

  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy[0] == busy[1]) && (busy[1] == busy[2]))
    else $error("divider lanes out of step");

  a_div_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_div |=> (busy == '1) && (state_q == ST_DIV))
    else $error("dividers not running after start");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !valid_q && (busy == '0))
    else $error("job taken while a result is pending");

endmodule
`default_nettype wire

/* rtl/three_point_quadratic_fit.sv */
// Top level of the three-point quadratic fit.
// After the completing request, a job passes the queue, the multiply steps, the divider lanes
//   and the output register, skipping the lanes when two x values coincide; points that complete
//   no window give no result. A new job is taken only once the last result has left the output.
// Until the two-entry queue is full, points keep flowing in while a result waits at the output.
// Reset (asynchronous, active low) empties the point window, the queue and the solver.
`default_nettype none
module three_point_quadratic_fit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tpqf_in_if.sink    in_i,
  tpqf_out_if.source out_o
);
  import tpqf_pkg::*;

  // The front end keeps the two newest points and forwards every complete window
  // as one job, with the equal-x check already made.
  job_t push_job, pop_job;
  logic push, pop, full, empty;

  tpqf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .job_o  (push_job),
    .push_o (push)
  );

  // The queue decouples point intake from the long solve.
  tpqf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_job)
  );

  // The back end forms the determinant and the three numerators in registered multiply
  // steps, then divides all three in parallel lanes and clips the results, unless two x values coincide.
  tpqf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (pop_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire
